### hw/rtl/crc16_frame_checker_core_defines.svh
// assertion macros shared by the crc16 frame checker rtl
// no dependencies; included by files that carry concurrent checks
`ifndef CRC16_FRAME_CHECKER_CORE_DEFINES_SVH
`define CRC16_FRAME_CHECKER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CRC16FC_ASSERT_SAME(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error("crc16 frame checker: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define CRC16FC_ASSERT_NEXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error("crc16 frame checker: next-cycle check failed");

`endif

### hw/rtl/crc16_fc_pkg.sv
// types and constants of the crc16 frame checker
// no dependencies; used by every module of the block
package crc16_fc_pkg;

  // crc-16/modbus constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // byte positions inside a frame
  localparam logic [8:0] POS_COMMAND = 9'd1;
  localparam logic [8:0] POS_LENGTH  = 9'd2;
  localparam logic [8:0] POS_PAYLOAD = 9'd3;

  // configuration register indexes
  localparam logic CFG_IDX_LENGTH_LIMIT = 1'b0;
  localparam logic CFG_IDX_CHECK_HIGH   = 1'b1;

  localparam logic [7:0] LENGTH_LIMIT_RESET = 8'd250;

  typedef enum logic [1:0] {
    STATUS_CRC_OK       = 2'd0,
    STATUS_CRC_MISMATCH = 2'd1,
    STATUS_ZERO_CMD     = 2'd2,
    STATUS_LEN_OVER     = 2'd3
  } status_t;

  // one result from the frame tracker to the output register
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [7:0]  command;
    logic [7:0]  payload_length;
    logic [15:0] crc_value;
  } result_t;

endpackage

### hw/rtl/crc16_fc_crc_byte.sv
// one-byte crc-16/modbus update, reflected polynomial, eight bit steps
// depends on crc16_fc_pkg for the polynomial
module crc16_fc_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  // xor the byte into the low end, then shift out eight bits
  always_comb begin
    logic [15:0] acc;
    acc = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ crc16_fc_pkg::CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_out = acc;
  end

endmodule

### hw/rtl/crc16_fc_frame_track.sv
// frame state: byte position, held command and length, running crc
// depends on crc16_fc_pkg, crc16_fc_crc_byte and the assertion macro header
`include "crc16_frame_checker_core_defines.svh"

module crc16_fc_frame_track (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  frame_start,
  input  logic [7:0]            length_limit,
  input  logic                  check_high_byte,
  output crc16_fc_pkg::result_t res
);

  logic        frame_active_r, frame_active_nxt;
  logic [8:0]  byte_position_r, byte_position_nxt;
  logic [7:0]  held_command_r, held_command_nxt;
  logic [7:0]  held_length_r, held_length_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic        low_crc_match_r, low_crc_match_nxt;

  logic [15:0] crc_base;
  logic [15:0] crc_upd;
  logic [8:0]  crc_lo_pos;
  logic [8:0]  crc_hi_pos;
  logic        match;

  // a header byte restarts the crc from its initial value
  assign crc_base = frame_start ? crc16_fc_pkg::CRC_INIT : running_crc_r;

  crc16_fc_crc_byte u_crc (
    .crc_in  (crc_base),
    .data_in (data_byte),
    .crc_out (crc_upd)
  );

  assign crc_lo_pos = crc16_fc_pkg::POS_PAYLOAD + {1'b0, held_length_r};
  assign crc_hi_pos = crc_lo_pos + 9'd1;
  assign match      = low_crc_match_r &
                      (!check_high_byte || (data_byte == running_crc_r[15:8]));

  // next state and result for the byte on hand
  always_comb begin
    frame_active_nxt  = frame_active_r;
    byte_position_nxt = byte_position_r;
    held_command_nxt  = held_command_r;
    held_length_nxt   = held_length_r;
    running_crc_nxt   = running_crc_r;
    low_crc_match_nxt = low_crc_match_r;
    res               = '0;
    res.status        = crc16_fc_pkg::STATUS_CRC_OK;
    if (step) begin
      if (frame_start) begin
        frame_active_nxt  = 1'b1;
        byte_position_nxt = crc16_fc_pkg::POS_COMMAND;
        held_command_nxt  = 8'h00;
        held_length_nxt   = 8'h00;
        low_crc_match_nxt = 1'b0;
        running_crc_nxt   = crc_upd;
      end else if (frame_active_r) begin
        if (byte_position_r == crc16_fc_pkg::POS_COMMAND) begin
          held_command_nxt = data_byte;
          running_crc_nxt  = crc_upd;
          if (data_byte == 8'h00) begin
            frame_active_nxt = 1'b0;
            res.valid        = 1'b1;
            res.status       = crc16_fc_pkg::STATUS_ZERO_CMD;
            res.crc_value    = crc_upd;
          end else begin
            byte_position_nxt = crc16_fc_pkg::POS_LENGTH;
          end
        end else if (byte_position_r == crc16_fc_pkg::POS_LENGTH) begin
          held_length_nxt = data_byte;
          running_crc_nxt = crc_upd;
          if (data_byte > length_limit) begin
            frame_active_nxt   = 1'b0;
            res.valid          = 1'b1;
            res.status         = crc16_fc_pkg::STATUS_LEN_OVER;
            res.command        = held_command_r;
            res.payload_length = data_byte;
            res.crc_value      = crc_upd;
          end else begin
            byte_position_nxt = crc16_fc_pkg::POS_PAYLOAD;
          end
        end else if (byte_position_r < crc_lo_pos) begin
          // payload byte
          running_crc_nxt   = crc_upd;
          byte_position_nxt = byte_position_r + 9'd1;
        end else if (byte_position_r == crc_lo_pos) begin
          // crc low byte, compare now and keep the outcome
          low_crc_match_nxt = (data_byte == running_crc_r[7:0]);
          byte_position_nxt = byte_position_r + 9'd1;
        end else begin
          // crc high byte closes the frame
          frame_active_nxt   = 1'b0;
          res.valid          = 1'b1;
          res.status         = match ? crc16_fc_pkg::STATUS_CRC_OK
                                     : crc16_fc_pkg::STATUS_CRC_MISMATCH;
          res.command        = held_command_r;
          res.payload_length = held_length_r;
          res.crc_value      = running_crc_r;
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r  <= 1'b0;
      byte_position_r <= 9'd0;
      held_command_r  <= 8'h00;
      held_length_r   <= 8'h00;
      running_crc_r   <= crc16_fc_pkg::CRC_INIT;
      low_crc_match_r <= 1'b0;
    end else begin
      frame_active_r  <= frame_active_nxt;
      byte_position_r <= byte_position_nxt;
      held_command_r  <= held_command_nxt;
      held_length_r   <= held_length_nxt;
      running_crc_r   <= running_crc_nxt;
      low_crc_match_r <= low_crc_match_nxt;
    end
  end

  // checks
  `CRC16FC_ASSERT_NEXT(a_result_ends_frame, clk, rst_n, res.valid, !frame_active_r)
  `CRC16FC_ASSERT_NEXT(a_start_opens_frame, clk, rst_n, step && frame_start,
    frame_active_r && (byte_position_r == crc16_fc_pkg::POS_COMMAND))
  `CRC16FC_ASSERT_SAME(a_position_bound, clk, rst_n,
    frame_active_r && (byte_position_r >= crc16_fc_pkg::POS_PAYLOAD),
    byte_position_r <= crc_hi_pos)

endmodule

### hw/rtl/crc16_frame_checker_core.sv
// top level of the crc16 frame checker: input register, config registers,
// frame tracker and result register; depends on crc16_fc_pkg,
// crc16_fc_frame_track and the assertion macro header
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | data_byte, frame_start
//  out_    | output    | out_valid/out_stall | status, command, payload_length, crc_value
//  cfg_    | input     | cfg_valid/cfg_ready | index (0 length limit, 1 high-byte check), data
//
// one byte per cycle sustained while no full result register is held by out_stall;
// a byte is held in the input register until the result register is free, and its
// result, if any, is loaded into the result register as the byte leaves. the per-byte
// crc update is an eight-step bit loop between the two registers. reset (rst_n low,
// synchronous) empties both registers and closes any frame. out_stall holds the result
// and back-pressures in_stall only when a byte waits in the input register behind a full result register.
`include "crc16_frame_checker_core_defines.svh"

module crc16_frame_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_command,
  output logic [7:0]  out_payload_length,
  output logic [15:0] out_crc_value,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic        out_valid_r, out_valid_nxt;
  crc16_fc_pkg::result_t out_res_r;
  logic [7:0]  length_limit_r;
  logic        check_high_r;
  logic        in_accept;
  logic        advance;
  crc16_fc_pkg::result_t res;

  // byte in the input register moves on when the result register is free
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (advance && res.valid) ? 1'b1
                                                : (out_stall ? out_valid_r : 1'b0);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_frame_start;
    end
  end

  // configuration registers, always ready for a transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_limit_r <= crc16_fc_pkg::LENGTH_LIMIT_RESET;
      check_high_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == crc16_fc_pkg::CFG_IDX_LENGTH_LIMIT) begin
        length_limit_r <= cfg_data;
      end
      if (cfg_index == crc16_fc_pkg::CFG_IDX_CHECK_HIGH) begin
        check_high_r <= cfg_data[0];
      end
    end
  end

  crc16_fc_frame_track u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .data_byte       (s1_byte_r),
    .frame_start     (s1_start_r),
    .length_limit    (length_limit_r),
    .check_high_byte (check_high_r),
    .res             (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_command        = out_res_r.command;
  assign out_payload_length = out_res_r.payload_length;
  assign out_crc_value      = out_res_r.crc_value;

  // checks
  `CRC16FC_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  `CRC16FC_ASSERT_SAME(a_zero_cmd_fields, clk, rst_n,
    out_valid && (out_status == crc16_fc_pkg::STATUS_ZERO_CMD),
    (out_command == 8'h00) && (out_payload_length == 8'h00))
  `CRC16FC_ASSERT_NEXT(a_result_loaded, clk, rst_n, advance && res.valid, out_valid)

endmodule
